// ===== sv/cjfc_pkg.sv =====
// Package with shared types and constants for the chunked job frame checker.
package cjfc_pkg;

    localparam logic [31:0] HDR_BYTES     = 32'd20;
    localparam logic [7:0]  PROTO_VERSION = 8'd2;
    localparam logic [7:0]  KIND_START    = 8'd1;
    localparam logic [7:0]  KIND_DATA     = 8'd2;
    localparam logic [7:0]  KIND_END      = 8'd3;
    localparam logic [31:0] START_MIN     = 32'd8;
    localparam logic [31:0] END_MIN       = 32'd4;
    localparam logic [31:0] MAGIC_WORD    = {8'h30, 8'h36, 8'h33, 8'h50};
    localparam int          QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_START,
        CLS_DATA,
        CLS_END
    } cls_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_OPEN    = 3'd1,
        ACT_REOPEN  = 3'd2,
        ACT_APPEND  = 3'd3,
        ACT_COMMIT  = 3'd4,
        ACT_DISCARD = 3'd5
    } act_t;

    typedef struct packed {
        cls_t        cls;
        logic        start_ok;
        logic        end_has_count;
        logic [31:0] job_id;
        logic [31:0] block_number;
        logic [31:0] payload_length;
        logic [31:0] payload_word0;
        logic [31:0] payload_word1;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

// ===== sv/cjfc_if.sv =====
// Channel interfaces for frame headers in and check results out.
interface cjfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_length;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [31:0] job_id;
    logic [31:0] block_number;
    logic [31:0] payload_length;
    logic [31:0] payload_word0;
    logic [31:0] payload_word1;

    modport source (
        output valid, frame_length, magic, version, frame_type, job_id,
               block_number, payload_length, payload_word0, payload_word1,
        input  ready
    );
    modport sink (
        input  valid, frame_length, magic, version, frame_type, job_id,
               block_number, payload_length, payload_word0, payload_word1,
        output ready
    );
endinterface

interface cjfc_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  action;
    logic [31:0] action_length;

    modport source (
        output valid, accepted, action, action_length,
        input  ready
    );
    modport sink (
        input  valid, accepted, action, action_length,
        output ready
    );
endinterface

// ===== sv/chunked_job_frame_checker.sv =====
// Top level of the chunked job frame checker: front end, command queue and back end.
// The queue stores each accepted input transaction and the back end registers its result.
// Throughput is one transaction per cycle while the result side is ready, set by the job update in the back end.
// Reset clears the job state, empties the queue and drops any pending result.
module chunked_job_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    cjfc_in_if.sink     frame_in,
    cjfc_out_if.source  result_out
);
    import cjfc_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    hs_t  push_hs;
    cmd_t queue_cmd;
    hs_t  pop_hs;
    logic back_ready;

    cjfc_front u_front (
        .frame_in  (frame_in),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (push_hs.ready)
    );

    cjfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_hs    (push_hs),
        .push_valid (front_valid),
        .pop_cmd    (queue_cmd),
        .pop_hs     (pop_hs),
        .pop_ready  (back_ready)
    );

    cjfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (queue_cmd),
        .cmd_hs     (pop_hs),
        .cmd_ready  (back_ready),
        .result_out (result_out)
    );

endmodule

// ===== sv/cjfc_front.sv =====
// Front end: checks the header and classifies each frame into a command.
module cjfc_front (
    cjfc_in_if.sink         frame_in,
    output cjfc_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import cjfc_pkg::*;

    logic hdr_ok;
    logic fits;
    logic name_fits;

    assign fits = ({1'b0, frame_in.payload_length} + {1'b0, HDR_BYTES})
                  <= {1'b0, frame_in.frame_length};
    assign hdr_ok = (frame_in.frame_length >= HDR_BYTES) && (frame_in.magic == MAGIC_WORD)
                    && (frame_in.version == PROTO_VERSION) && fits;
    assign name_fits = ({1'b0, frame_in.payload_word1} + {1'b0, START_MIN})
                       <= {1'b0, frame_in.payload_length};

    always_comb
    begin
        cmd.cls = CLS_NONE;
        if (hdr_ok)
        begin
            case (frame_in.frame_type)
                KIND_START: cmd.cls = CLS_START;
                KIND_DATA:  cmd.cls = CLS_DATA;
                KIND_END:   cmd.cls = CLS_END;
                default:    cmd.cls = CLS_NONE;
            endcase
        end
        cmd.start_ok       = (frame_in.payload_length >= START_MIN) && name_fits;
        cmd.end_has_count  = frame_in.payload_length >= END_MIN;
        cmd.job_id         = frame_in.job_id;
        cmd.block_number   = frame_in.block_number;
        cmd.payload_length = frame_in.payload_length;
        cmd.payload_word0  = frame_in.payload_word0;
        cmd.payload_word1  = frame_in.payload_word1;
    end

    assign cmd_valid      = frame_in.valid;
    assign frame_in.ready = cmd_ready;

endmodule

// ===== sv/cjfc_queue.sv =====
// Two-entry command queue between the front end and the back end.
module cjfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  cjfc_pkg::cmd_t  push_cmd,
    output cjfc_pkg::hs_t   push_hs,
    input  logic            push_valid,
    output cjfc_pkg::cmd_t  pop_cmd,
    output cjfc_pkg::hs_t   pop_hs,
    input  logic            pop_ready
);
    import cjfc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_hs.valid = push_valid;
    assign push_hs.ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_hs.valid  = count_reg != '0;
    assign pop_hs.ready  = pop_ready;
    assign pop_cmd       = mem_reg[rd_ptr_reg];

    assign push = push_hs.valid && push_hs.ready;
    assign pop  = pop_hs.valid && pop_hs.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(QUEUE_DEPTH)) && !pop |=> count_reg == CNT_W'(QUEUE_DEPTH))
        else $error("queue count changed while full and idle");

    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) && !push |=> count_reg == '0)
        else $error("queue count changed while empty and idle");

endmodule

// ===== sv/cjfc_back.sv =====
// Back end: holds the open job state, executes commands and registers the result.
module cjfc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cjfc_pkg::cmd_t  cmd,
    input  cjfc_pkg::hs_t   cmd_hs,
    output logic            cmd_ready,
    cjfc_out_if.source      result_out
);
    import cjfc_pkg::*;

    logic        job_open_reg;
    logic        job_open_next;
    logic [31:0] current_job_reg;
    logic [31:0] current_job_next;
    logic [31:0] expected_total_reg;
    logic [31:0] expected_total_next;
    logic [31:0] bytes_received_reg;
    logic [31:0] bytes_received_next;
    logic [31:0] blocks_received_reg;
    logic [31:0] blocks_received_next;

    logic        out_valid_reg;
    logic        out_accepted_reg;
    act_t        out_action_reg;
    logic [31:0] out_length_reg;

    logic        res_accepted;
    act_t        res_action;
    logic [31:0] res_length;
    logic        pop;
    logic        job_match;
    logic [31:0] want_blocks;
    logic        end_ok;

    assign cmd_ready = !out_valid_reg || result_out.ready;
    assign pop       = cmd_hs.valid && cmd_ready;
    assign job_match = job_open_reg && (cmd.job_id == current_job_reg);
    assign want_blocks = cmd.end_has_count ? cmd.payload_word0 : blocks_received_reg;
    assign end_ok = (bytes_received_reg == expected_total_reg)
                    && (blocks_received_reg == want_blocks);

    always_comb
    begin
        job_open_next        = job_open_reg;
        current_job_next     = current_job_reg;
        expected_total_next  = expected_total_reg;
        bytes_received_next  = bytes_received_reg;
        blocks_received_next = blocks_received_reg;
        res_accepted         = 1'b0;
        res_action           = ACT_NONE;
        res_length           = '0;
        case (cmd.cls)
            CLS_START:
            begin
                job_open_next        = 1'b0;
                current_job_next     = '0;
                expected_total_next  = '0;
                bytes_received_next  = '0;
                blocks_received_next = '0;
                if (cmd.start_ok)
                begin
                    job_open_next       = 1'b1;
                    current_job_next    = cmd.job_id;
                    expected_total_next = cmd.payload_word0;
                    res_accepted        = 1'b1;
                    res_action          = job_open_reg ? ACT_REOPEN : ACT_OPEN;
                    res_length          = cmd.payload_word1;
                end
                else
                begin
                    res_action = job_open_reg ? ACT_DISCARD : ACT_NONE;
                end
            end
            CLS_DATA:
            begin
                if (job_match)
                begin
                    if (cmd.block_number != blocks_received_reg)
                    begin
                        job_open_next        = 1'b0;
                        current_job_next     = '0;
                        expected_total_next  = '0;
                        bytes_received_next  = '0;
                        blocks_received_next = '0;
                        res_action           = ACT_DISCARD;
                    end
                    else
                    begin
                        bytes_received_next  = bytes_received_reg + cmd.payload_length;
                        blocks_received_next = blocks_received_reg + 32'd1;
                        res_accepted         = 1'b1;
                        res_action           = ACT_APPEND;
                        res_length           = cmd.payload_length;
                    end
                end
            end
            CLS_END:
            begin
                if (job_match)
                begin
                    job_open_next        = 1'b0;
                    current_job_next     = '0;
                    expected_total_next  = '0;
                    bytes_received_next  = '0;
                    blocks_received_next = '0;
                    res_accepted         = end_ok;
                    res_action           = end_ok ? ACT_COMMIT : ACT_DISCARD;
                end
            end
            default:
            begin
                res_action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_open_reg        <= 1'b0;
            current_job_reg     <= '0;
            expected_total_reg  <= '0;
            bytes_received_reg  <= '0;
            blocks_received_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_open_reg        <= job_open_next;
                current_job_reg     <= current_job_next;
                expected_total_reg  <= expected_total_next;
                bytes_received_reg  <= bytes_received_next;
                blocks_received_reg <= blocks_received_next;
                out_valid_reg       <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_accepted_reg <= res_accepted;
            out_action_reg   <= res_action;
            out_length_reg   <= res_length;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.accepted      = out_accepted_reg;
    assign result_out.action        = out_action_reg;
    assign result_out.action_length = out_length_reg;

    a_closed_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !job_open_reg |-> (bytes_received_reg == '0) && (blocks_received_reg == '0)
                          && (current_job_reg == '0) && (expected_total_reg == '0))
        else $error("closed job left counters set");

    a_accept_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_accepted_reg |->
            (out_action_reg == ACT_OPEN) || (out_action_reg == ACT_REOPEN)
            || (out_action_reg == ACT_APPEND) || (out_action_reg == ACT_COMMIT))
        else $error("accepted result carries a non-success action");

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (cmd.cls == CLS_START) && cmd.start_ok |=> job_open_reg)
        else $error("valid start did not open a job");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (cmd.cls == CLS_END) && job_match |=> !job_open_reg)
        else $error("end frame left a job open");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chunked job frame checker with a job-tracking scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import cjfc_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_FRAMES    = 165;

    typedef struct {
        logic [31:0] frame_length;
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  frame_type;
        logic [31:0] job_id;
        logic [31:0] block_number;
        logic [31:0] payload_length;
        logic [31:0] payload_word0;
        logic [31:0] payload_word1;
    } frame_hdr_t;

    typedef struct {
        logic        accepted;
        act_t        action;
        logic [31:0] action_length;
    } verdict_t;

    class frame_verdict_board;
        logic        job_open;
        logic [31:0] current_job;
        logic [31:0] expected_total;
        logic [31:0] bytes_received;
        logic [31:0] blocks_received;
        verdict_t    pending_verdicts[$];
        int          errors;
        int          frames_noted;
        int          results_checked;
        int          action_tally[6];

        function new();
            close_job();
            errors = 0;
            frames_noted = 0;
            results_checked = 0;
            foreach (action_tally[i])
                action_tally[i] = 0;
        endfunction

        function void close_job();
            job_open = 1'b0;
            current_job = '0;
            expected_total = '0;
            bytes_received = '0;
            blocks_received = '0;
        endfunction

        function verdict_t judge_frame(frame_hdr_t f);
            verdict_t    v;
            logic        had;
            logic        ok;
            logic [31:0] want;
            v.accepted = 1'b0;
            v.action = ACT_NONE;
            v.action_length = '0;
            if (f.frame_length < HDR_BYTES || f.magic != MAGIC_WORD || f.version != PROTO_VERSION
                || {1'b0, HDR_BYTES} + {1'b0, f.payload_length} > {1'b0, f.frame_length})
                return v;
            case (f.frame_type)
                KIND_START:
                begin
                    had = job_open;
                    if (had)
                        close_job();
                    if (f.payload_length < START_MIN
                        || {1'b0, START_MIN} + {1'b0, f.payload_word1} > {1'b0, f.payload_length})
                    begin
                        if (had)
                            v.action = ACT_DISCARD;
                    end
                    else
                    begin
                        job_open = 1'b1;
                        current_job = f.job_id;
                        expected_total = f.payload_word0;
                        bytes_received = '0;
                        blocks_received = '0;
                        v.accepted = 1'b1;
                        v.action = had ? ACT_REOPEN : ACT_OPEN;
                        v.action_length = f.payload_word1;
                    end
                end
                KIND_DATA:
                begin
                    if (job_open && f.job_id == current_job)
                    begin
                        if (f.block_number != blocks_received)
                        begin
                            close_job();
                            v.action = ACT_DISCARD;
                        end
                        else
                        begin
                            bytes_received = bytes_received + f.payload_length;
                            blocks_received = blocks_received + 32'd1;
                            v.accepted = 1'b1;
                            v.action = ACT_APPEND;
                            v.action_length = f.payload_length;
                        end
                    end
                end
                KIND_END:
                begin
                    if (job_open && f.job_id == current_job)
                    begin
                        want = (f.payload_length >= END_MIN) ? f.payload_word0 : blocks_received;
                        ok = (bytes_received == expected_total) && (blocks_received == want);
                        close_job();
                        v.accepted = ok;
                        v.action = ok ? ACT_COMMIT : ACT_DISCARD;
                    end
                end
                default:
                    ;
            endcase
            return v;
        endfunction

        function void note_frame(frame_hdr_t f);
            pending_verdicts.push_back(judge_frame(f));
            frames_noted++;
        endfunction

        function void check_verdict(logic accepted, logic [2:0] action, logic [31:0] action_length);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction arrived with no frame outstanding");
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            results_checked++;
            action_tally[int'(want.action)]++;
            if (accepted !== want.accepted)
            begin
                $error("accepted: expected %0b, got %0b", want.accepted, accepted);
                errors++;
            end
            if (action !== want.action)
            begin
                $error("action: expected %0d, got %0d", want.action, action);
                errors++;
            end
            if (action_length !== want.action_length)
            begin
                $error("action_length: expected 0x%08h, got 0x%08h",
                       want.action_length, action_length);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;
    int frames_offered = 0;

    frame_verdict_board sb = new();

    cjfc_in_if  frame_in ();
    cjfc_out_if result_out ();

    chunked_job_frame_checker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .result_out (result_out)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin : monitor
        frame_hdr_t seen;
        if (rst_n && frame_in.valid && frame_in.ready)
        begin
            seen.frame_length = frame_in.frame_length;
            seen.magic = frame_in.magic;
            seen.version = frame_in.version;
            seen.frame_type = frame_in.frame_type;
            seen.job_id = frame_in.job_id;
            seen.block_number = frame_in.block_number;
            seen.payload_length = frame_in.payload_length;
            seen.payload_word0 = frame_in.payload_word0;
            seen.payload_word1 = frame_in.payload_word1;
            sb.note_frame(seen);
        end
        if (rst_n && result_out.valid && result_out.ready)
            sb.check_verdict(result_out.accepted, result_out.action, result_out.action_length);
    end

    initial
    begin
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        result_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_off_requests)
            begin
                served = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_out.ready <= 1'b0;
            end
            else
                result_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((frame_in.valid && frame_in.ready) || (result_out.valid && result_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic frame_hdr_t make_frame(input logic [7:0] kind, input logic [31:0] job,
                                              input logic [31:0] blk, input logic [31:0] plen,
                                              input logic [31:0] w0, input logic [31:0] w1);
        frame_hdr_t      f;
        longint unsigned room;
        longint unsigned slack;
        room = 64'hFFFF_FFFF - 64'(HDR_BYTES) - 64'(plen);
        slack = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 8));
        if (slack > room)
            slack = room;
        f.frame_length = 32'(64'(HDR_BYTES) + 64'(plen) + slack);
        f.magic = MAGIC_WORD;
        f.version = PROTO_VERSION;
        f.frame_type = kind;
        f.job_id = job;
        f.block_number = blk;
        f.payload_length = plen;
        f.payload_word0 = w0;
        f.payload_word1 = w1;
        return f;
    endfunction

    function automatic logic [31:0] pick_block_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 32'hFFFF_FFEB);
        return $urandom_range(0, 64);
    endfunction

    function automatic frame_hdr_t noise_frame(input logic [31:0] job);
        frame_hdr_t f;
        f = make_frame(8'($urandom_range(1, 3)), job, $urandom_range(0, 3),
                       $urandom_range(0, 24), $urandom, $urandom);
        case ($urandom_range(0, 7))
            0:
            begin
                f.frame_length = $urandom;
                f.magic = $urandom;
                f.version = 8'($urandom);
                f.frame_type = 8'($urandom);
                f.job_id = $urandom;
                f.block_number = $urandom;
                f.payload_length = $urandom;
            end
            1:
                f.magic = f.magic ^ (32'd1 << $urandom_range(0, 31));
            2:
                f.version = f.version ^ (8'd1 << $urandom_range(0, 7));
            3:
                f.frame_length = $urandom_range(0, 19);
            4:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    f.frame_length = '1;
                    f.payload_length = $urandom_range(32'hFFFF_FFEC, 32'hFFFF_FFFF);
                end
                else
                begin
                    f.frame_length = HDR_BYTES + $urandom_range(0, 100);
                    f.payload_length = f.frame_length - HDR_BYTES + 32'd1 + $urandom_range(0, 3);
                end
            end
            5:
                f.frame_type = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(4, 255));
            6:
                f.job_id = job ^ (32'd1 << $urandom_range(0, 31));
            default:
            begin
                f.frame_type = KIND_START;
                if ($urandom_range(0, 1) == 0)
                    f.payload_length = $urandom_range(0, 7);
                else
                    f.payload_word1 = f.payload_length - START_MIN + 32'd1
                                      + $urandom_range(0, 32'hFFFF_FFFF);
                f.frame_length = HDR_BYTES + f.payload_length;
            end
        endcase
        return f;
    endfunction

    task automatic send_frame(input frame_hdr_t f);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid <= 1'b1;
        frame_in.frame_length <= f.frame_length;
        frame_in.magic <= f.magic;
        frame_in.version <= f.version;
        frame_in.frame_type <= f.frame_type;
        frame_in.job_id <= f.job_id;
        frame_in.block_number <= f.block_number;
        frame_in.payload_length <= f.payload_length;
        frame_in.payload_word0 <= f.payload_word0;
        frame_in.payload_word1 <= f.payload_word1;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        frames_offered++;
    endtask

    task automatic run_job();
        logic [31:0] job;
        logic [31:0] total;
        logic [31:0] name_len;
        logic [31:0] blk;
        logic [31:0] lens[$];
        int          n_blocks;
        int          flaw;
        job = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
        n_blocks = $urandom_range(0, 6);
        flaw = $urandom_range(0, 12);
        total = '0;
        for (int i = 0; i < n_blocks; i++)
        begin
            lens.push_back(pick_block_length());
            total = total + lens[i];
        end
        if (flaw == 6)
            total = total + 32'd1 + $urandom_range(0, 5);
        name_len = $urandom_range(0, 40);
        send_frame(make_frame(KIND_START, job, $urandom, START_MIN + name_len + $urandom_range(0, 16),
                              total, name_len));
        for (int i = 0; i < n_blocks; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_frame(noise_frame(job));
            blk = i;
            if (flaw == 7 && i == n_blocks - 1)
                blk = i + 1 + $urandom_range(0, 3);
            send_frame(make_frame(KIND_DATA, job, blk, lens[i], $urandom, $urandom));
        end
        if (flaw == 10)
            return;
        if (flaw == 9)
            send_frame(make_frame(KIND_END, job, $urandom, $urandom_range(0, 3), $urandom, $urandom));
        else
            send_frame(make_frame(KIND_END, job, $urandom, $urandom_range(4, 16),
                                  (flaw == 8) ? n_blocks + 1 : n_blocks, $urandom));
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        stop_at = frames_offered + count;
        while (frames_offered < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
                run_job();
            else
                send_frame(noise_frame($urandom_range(0, 7)));
        end
    endtask

    task automatic wait_for_results();
        frame_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        frame_hdr_t f;
        frame_hdr_t base;
        rst_n <= 1'b0;
        frame_in.valid <= 1'b0;
        frame_in.frame_length <= '0;
        frame_in.magic <= '0;
        frame_in.version <= '0;
        frame_in.frame_type <= '0;
        frame_in.job_id <= '0;
        frame_in.block_number <= '0;
        frame_in.payload_length <= '0;
        frame_in.payload_word0 <= '0;
        frame_in.payload_word1 <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Two maximal blocks make the byte count wrap before the commit.
        f = make_frame(KIND_START, 32'd5, 32'd0, START_MIN, 32'hFFFF_FFD6, 32'd0);
        f.frame_length = HDR_BYTES + START_MIN;
        send_frame(f);
        send_frame(make_frame(KIND_DATA, 32'd5, 32'd0, 32'hFFFF_FFEB, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_frame(make_frame(KIND_DATA, 32'd5, 32'd1, 32'hFFFF_FFEB, 32'd0, 32'd0));
        send_frame(make_frame(KIND_END, 32'd5, 32'd0, END_MIN, 32'd2, 32'd0));
        send_frame(make_frame(KIND_END, 32'd5, 32'd0, END_MIN, 32'd2, 32'd0));
        send_frame(make_frame(KIND_DATA, 32'd5, 32'd0, 32'd4, 32'd0, 32'd0));
        // The name length only overflows the payload when summed in 33 bits.
        send_frame(make_frame(KIND_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20, 32'd3,
                              32'hFFFF_FFFC));
        send_frame(make_frame(KIND_START, 32'hFFFF_FFFF, 32'd0, 32'd20, 32'd3, 32'd12));
        send_frame(make_frame(KIND_START, 32'd7, 32'd0, 32'd7, 32'd0, 32'd0));
        send_frame(make_frame(KIND_START, 32'd7, 32'd0, START_MIN, 32'd0, 32'd0));
        send_frame(make_frame(KIND_START, 32'd9, 32'd0, START_MIN, 32'd5, 32'd0));
        send_frame(make_frame(KIND_DATA, 32'd8, 32'd0, 32'd5, 32'd0, 32'd0));
        send_frame(make_frame(KIND_DATA, 32'd9, 32'd1, 32'd5, 32'd0, 32'd0));
        send_frame(make_frame(KIND_START, 32'd9, 32'd0, 32'd12, 32'd5, 32'd4));
        send_frame(make_frame(KIND_DATA, 32'd9, 32'd0, 32'd5, 32'd0, 32'd0));
        send_frame(make_frame(KIND_END, 32'd9, 32'd0, 32'd3, 32'd99, 32'd0));
        send_frame(make_frame(KIND_START, 32'd1, 32'd0, START_MIN, 32'd1, 32'd0));
        send_frame(make_frame(KIND_END, 32'd1, 32'd0, END_MIN, 32'd0, 32'd0));
        // Malformed headers must leave the open job untouched.
        send_frame(make_frame(KIND_START, 32'd2, 32'd0, START_MIN, 32'd0, 32'd0));
        base = make_frame(KIND_END, 32'd2, 32'd0, END_MIN, 32'd0, 32'd0);
        f = base;
        f.frame_length = HDR_BYTES - 32'd1;
        send_frame(f);
        f = base;
        f.magic = ~MAGIC_WORD;
        send_frame(f);
        f = base;
        f.version = PROTO_VERSION + 8'd1;
        send_frame(f);
        f = base;
        f.frame_length = HDR_BYTES + END_MIN - 32'd1;
        send_frame(f);
        f = base;
        f.frame_length = '1;
        f.payload_length = 32'hFFFF_FFEC;
        send_frame(f);
        f = base;
        f.frame_type = 8'd0;
        send_frame(f);
        f = base;
        f.frame_type = 8'hFF;
        send_frame(f);
        send_frame(base);
        wait_for_results();

        hold_off_requests++;
        random_traffic(24);
        wait_for_results();

        random_traffic(PHASE_FRAMES);
        wait_for_results();
        send_idle_pct = 85;
        random_traffic(PHASE_FRAMES);
        wait_for_results();
        send_idle_pct = 0;
        recv_stall_pct = 85;
        random_traffic(PHASE_FRAMES);
        wait_for_results();
        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_traffic(PHASE_FRAMES);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d headers in four idle/stall mixes and a long hold-off, %0d compared",
                 sb.frames_noted, sb.results_checked);
        $display("tb: open %0d, reopen %0d, append %0d, commit %0d, discard %0d, none %0d",
                 sb.action_tally[ACT_OPEN], sb.action_tally[ACT_REOPEN],
                 sb.action_tally[ACT_APPEND], sb.action_tally[ACT_COMMIT],
                 sb.action_tally[ACT_DISCARD], sb.action_tally[ACT_NONE]);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
